// ===== rtl/rdpc_pkg.sv =====
package rdpc_pkg;

    // Default number of CORDIC micro-rotations (legal range 8 to 24).
    localparam int ANGLE_ITERATIONS_DEF = 16;

    // Field widths.
    localparam int COORD_W = 24;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Internal datapath widths. Growth of the CORDIC is bounded by the gain
    // of an endless rotation, so these do not depend on the iteration count.
    localparam int PW  = 51;   // point in Q24
    localparam int VW  = 43;   // velocity in Q32
    localparam int RW  = 32;   // displacement in Q20 times the CORDIC gain
    localparam int DW  = 26;   // rounded displacement in Q12
    localparam int OW  = 22;   // displacement of a point at the origin
    localparam int FRAC_SHIFT = 24;

    // Split of the velocity for the two partial products with beta.
    localparam int VLO_W = 21;
    localparam int VHI_W = VW - VLO_W;
    localparam int PP_W  = CFG_W + 1 + VHI_W;
    localparam int DPROD_SHIFT = 28;

    // 1/K^2 in Q30 and the rounding that brings the product to Q12.
    localparam int          GAIN_W    = 30;
    localparam logic [29:0] INV_GAIN2 = 30'd395948876;
    localparam int          RND_SHIFT = 38;
    localparam int          PROD_W    = RW + GAIN_W + 1;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sh800000;

    localparam logic [CFG_W-1:0] DOPPLER_GAIN_RST = 16'd3211;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOPPLER_GAIN = 2'd0,
        CFG_VELOCITY_X   = 2'd1,
        CFG_VELOCITY_Y   = 2'd2
    } cfg_reg_t;

    // Side information that travels with each point through the pipeline.
    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      flip;
        logic                      origin;
    } side_t;

endpackage

// ===== rtl/radar_doppler_point_correction_unit.sv =====
// Throughput: one point per cycle while no result waits unread; each CORDIC micro-rotation has its own stage.
// The whole pipeline advances together and holds only while a result waits unread.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the configuration
// registers with beta = 3211 and zero sensor velocity.
module radar_doppler_point_correction_unit #(
    parameter int ANGLE_ITERATIONS = rdpc_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rdpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rdpc_pkg::CFG_W-1:0]           cfg_data,
    // Input point channel.
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [rdpc_pkg::COORD_W-1:0]  point_x,
    input  logic signed [rdpc_pkg::COORD_W-1:0]  point_y,
    // Corrected point channel.
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rdpc_pkg::COORD_W-1:0]  corrected_x,
    output logic signed [rdpc_pkg::COORD_W-1:0]  corrected_y,
    output logic                                 saturated
);

    localparam int N   = ANGLE_ITERATIONS;
    localparam int LAT = 2 * N + 6;
    localparam int PW  = rdpc_pkg::PW;
    localparam int VW  = rdpc_pkg::VW;
    localparam int RW  = rdpc_pkg::RW;
    localparam int DW  = rdpc_pkg::DW;
    localparam int OW  = rdpc_pkg::OW;
    localparam int CW  = rdpc_pkg::COORD_W;
    localparam int FS  = rdpc_pkg::FRAC_SHIFT;

    // ------------------------------------------------------------------
    // Configuration registers. The port never stalls; writes must arrive
    // only while the pipeline is empty (the block does not enforce this),
    // so the datapath reads them directly. An index beyond the register list is dropped.
    // ------------------------------------------------------------------
    logic [rdpc_pkg::CFG_W-1:0]        beta_reg;
    logic signed [rdpc_pkg::CFG_W-1:0] vx_reg;
    logic signed [rdpc_pkg::CFG_W-1:0] vy_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg <= rdpc_pkg::DOPPLER_GAIN_RST;
            vx_reg   <= '0;
            vy_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rdpc_pkg::CFG_DOPPLER_GAIN: beta_reg <= cfg_data;
                rdpc_pkg::CFG_VELOCITY_X:   vx_reg   <= cfg_data;
                rdpc_pkg::CFG_VELOCITY_Y:   vy_reg   <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // A point at the origin has bearing zero, so its shift is beta*vx rounded
    // from Q24 to Q12. It depends on configuration alone and is kept here.
    logic signed [2*rdpc_pkg::CFG_W:0]   orig_prod;
    logic signed [2*rdpc_pkg::CFG_W+1:0] orig_sum;
    logic signed [OW-1:0]                orig_dx_next;
    logic signed [OW-1:0]                orig_dx_reg;

    always_comb
    begin
        orig_prod    = $signed({1'b0, beta_reg}) * vx_reg;
        orig_sum     = {orig_prod[2*rdpc_pkg::CFG_W], orig_prod}
                       + (2*rdpc_pkg::CFG_W+2)'(2048);
        orig_dx_next = orig_sum[OW+11:12];
    end

    always_ff @(posedge clk)
    begin
        orig_dx_reg <= orig_dx_next;
    end

    // ------------------------------------------------------------------
    // Flow control. Every stage moves when the output register is free or
    // is being read in this cycle; valid bits shift with the data.
    // ------------------------------------------------------------------
    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: points with negative x are turned by pi (point and velocity
    // negated) so the CORDIC stays in the right half plane. Both vectors
    // are scaled into their wide fixed-point formats.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] fx_reg  [0:N];
    logic signed [PW-1:0] fy_reg  [0:N];
    logic signed [VW-1:0] fu_reg  [0:N];
    logic signed [VW-1:0] fv_reg  [0:N];
    logic [N-1:0]         fcw_reg [0:N];
    rdpc_pkg::side_t      fs_reg  [0:N];

    logic signed [PW-1:0] fx_next  [0:N];
    logic signed [PW-1:0] fy_next  [0:N];
    logic signed [VW-1:0] fu_next  [0:N];
    logic signed [VW-1:0] fv_next  [0:N];
    logic [N-1:0]         fcw_next [0:N];
    rdpc_pkg::side_t      fs_next  [0:N];

    logic signed [CW:0]                 ax;
    logic signed [CW:0]                 ay;
    logic signed [rdpc_pkg::CFG_W:0]    av;
    logic signed [rdpc_pkg::CFG_W:0]    aw;
    logic                               flip;

    always_comb
    begin
        flip = point_x[CW-1];
        ax   = flip ? -{point_x[CW-1], point_x} : {point_x[CW-1], point_x};
        ay   = flip ? -{point_y[CW-1], point_y} : {point_y[CW-1], point_y};
        av   = flip ? -{vx_reg[rdpc_pkg::CFG_W-1], vx_reg} : {vx_reg[rdpc_pkg::CFG_W-1], vx_reg};
        aw   = flip ? -{vy_reg[rdpc_pkg::CFG_W-1], vy_reg} : {vy_reg[rdpc_pkg::CFG_W-1], vy_reg};
        fx_next[0]  = {{(PW-CW-1-FS){ax[CW]}}, ax, {FS{1'b0}}};
        fy_next[0]  = {{(PW-CW-1-FS){ay[CW]}}, ay, {FS{1'b0}}};
        fu_next[0]  = {{(VW-rdpc_pkg::CFG_W-1-FS){av[rdpc_pkg::CFG_W]}}, av, {FS{1'b0}}};
        fv_next[0]  = {{(VW-rdpc_pkg::CFG_W-1-FS){aw[rdpc_pkg::CFG_W]}}, aw, {FS{1'b0}}};
        fcw_next[0] = '0;
        fs_next[0].px     = point_x;
        fs_next[0].py     = point_y;
        fs_next[0].flip   = flip;
        fs_next[0].origin = (point_x == '0) && (point_y == '0);
    end

    // ------------------------------------------------------------------
    // Forward CORDIC in vectoring mode: stage i+1 performs micro-rotation i
    // on the point and applies the same rotation to the velocity. The
    // direction of each step is recorded for the back rotation.
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_fwd
            always_comb
            begin
                fcw_next[gi+1] = fcw_reg[gi];
                fs_next[gi+1]  = fs_reg[gi];
                if (!fy_reg[gi][PW-1])
                begin
                    fcw_next[gi+1][gi] = 1'b1;
                    fx_next[gi+1] = fx_reg[gi] + (fy_reg[gi] >>> gi);
                    fy_next[gi+1] = fy_reg[gi] - (fx_reg[gi] >>> gi);
                    fu_next[gi+1] = fu_reg[gi] + (fv_reg[gi] >>> gi);
                    fv_next[gi+1] = fv_reg[gi] - (fu_reg[gi] >>> gi);
                end
                else
                begin
                    fx_next[gi+1] = fx_reg[gi] - (fy_reg[gi] >>> gi);
                    fy_next[gi+1] = fy_reg[gi] + (fx_reg[gi] >>> gi);
                    fu_next[gi+1] = fu_reg[gi] - (fv_reg[gi] >>> gi);
                    fv_next[gi+1] = fv_reg[gi] + (fu_reg[gi] >>> gi);
                end
            end
        end

        for (gi = 0; gi <= N; gi++)
        begin : g_fwd_reg
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    fx_reg[gi]  <= fx_next[gi];
                    fy_reg[gi]  <= fy_next[gi];
                    fu_reg[gi]  <= fu_next[gi];
                    fv_reg[gi]  <= fv_next[gi];
                    fcw_reg[gi] <= fcw_next[gi];
                    fs_reg[gi]  <= fs_next[gi];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Radial velocity times beta. The rotated x velocity is split in two
    // halves so that each partial product stays narrow; the second stage
    // adds them and drops 28 fraction bits (floor).
    // ------------------------------------------------------------------
    localparam int VLO_W = rdpc_pkg::VLO_W;
    localparam int VHI_W = rdpc_pkg::VHI_W;
    localparam int PP_W  = rdpc_pkg::PP_W;
    localparam int SUM_W = PP_W + VLO_W;

    logic signed [PP_W-1:0] pphi_next;
    logic signed [PP_W-1:0] pplo_next;
    logic signed [PP_W-1:0] pphi_reg;
    logic signed [PP_W-1:0] pplo_reg;
    logic [N-1:0]           mcw_reg;
    rdpc_pkg::side_t        ms_reg;

    always_comb
    begin
        pphi_next = $signed({1'b0, beta_reg}) * $signed(fu_reg[N][VW-1:VLO_W]);
        pplo_next = PP_W'($signed({1'b0, beta_reg}) * $signed({1'b0, fu_reg[N][VLO_W-1:0]}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pphi_reg <= pphi_next;
            pplo_reg <= pplo_next;
            mcw_reg  <= fcw_reg[N];
            ms_reg   <= fs_reg[N];
        end
    end

    logic signed [SUM_W-1:0] dsum;
    logic signed [RW-1:0]    brx_reg  [0:N];
    logic signed [RW-1:0]    bry_reg  [0:N];
    logic [N-1:0]            bcw_reg  [0:N];
    rdpc_pkg::side_t         bs_reg   [0:N];
    logic signed [RW-1:0]    brx_next [0:N];
    logic signed [RW-1:0]    bry_next [0:N];

    always_comb
    begin
        dsum = {pphi_reg, {VLO_W{1'b0}}} + {{VLO_W{pplo_reg[PP_W-1]}}, pplo_reg};
        brx_next[0] = dsum[RW+rdpc_pkg::DPROD_SHIFT-1:rdpc_pkg::DPROD_SHIFT];
        bry_next[0] = '0;
    end

    // ------------------------------------------------------------------
    // Back rotation: the recorded micro-rotations are undone in reverse
    // order, which turns (delta, 0) onto the bearing of the point.
    // ------------------------------------------------------------------
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_back
            localparam int S = N - 1 - gi;
            always_comb
            begin
                if (bcw_reg[gi][S])
                begin
                    brx_next[gi+1] = brx_reg[gi] - (bry_reg[gi] >>> S);
                    bry_next[gi+1] = bry_reg[gi] + (brx_reg[gi] >>> S);
                end
                else
                begin
                    brx_next[gi+1] = brx_reg[gi] + (bry_reg[gi] >>> S);
                    bry_next[gi+1] = bry_reg[gi] - (brx_reg[gi] >>> S);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    bcw_reg[gi+1] <= bcw_reg[gi];
                    bs_reg[gi+1]  <= bs_reg[gi];
                end
            end
        end

        for (gi = 0; gi <= N; gi++)
        begin : g_back_reg
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    brx_reg[gi] <= brx_next[gi];
                    bry_reg[gi] <= bry_next[gi];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bcw_reg[0] <= mcw_reg;
            bs_reg[0]  <= ms_reg;
        end
    end

    // ------------------------------------------------------------------
    // Gain removal: multiply by 1/K^2, then round half up to Q12.
    // ------------------------------------------------------------------
    localparam int PROD_W = rdpc_pkg::PROD_W;

    logic signed [PROD_W-1:0] prx_next;
    logic signed [PROD_W-1:0] pry_next;
    logic signed [PROD_W-1:0] prx_reg;
    logic signed [PROD_W-1:0] pry_reg;
    rdpc_pkg::side_t          ps_reg;

    always_comb
    begin
        prx_next = PROD_W'(brx_reg[N] * $signed({1'b0, rdpc_pkg::INV_GAIN2}));
        pry_next = PROD_W'(bry_reg[N] * $signed({1'b0, rdpc_pkg::INV_GAIN2}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prx_reg <= prx_next;
            pry_reg <= pry_next;
            ps_reg  <= bs_reg[N];
        end
    end

    logic signed [PROD_W-1:0] rndx;
    logic signed [PROD_W-1:0] rndy;
    logic signed [DW-1:0]     qx;
    logic signed [DW-1:0]     qy;
    logic signed [DW-1:0]     dx_next;
    logic signed [DW-1:0]     dy_next;
    logic signed [DW-1:0]     dx_reg;
    logic signed [DW-1:0]     dy_reg;
    rdpc_pkg::side_t          rs_reg;

    // The rounded product keeps its sign bit on top of the bits above the
    // Q12 point, which gives exactly DW bits.
    always_comb
    begin
        rndx = prx_reg + (PROD_W'(1) <<< (rdpc_pkg::RND_SHIFT - 1));
        rndy = pry_reg + (PROD_W'(1) <<< (rdpc_pkg::RND_SHIFT - 1));
        qx   = {rndx[PROD_W-1], rndx[PROD_W-1:rdpc_pkg::RND_SHIFT]};
        qy   = {rndy[PROD_W-1], rndy[PROD_W-1:rdpc_pkg::RND_SHIFT]};
        if (ps_reg.origin)
        begin
            dx_next = DW'(orig_dx_reg);
            dy_next = '0;
        end
        else if (ps_reg.flip)
        begin
            dx_next = -qx;
            dy_next = -qy;
        end
        else
        begin
            dx_next = qx;
            dy_next = qy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            rs_reg <= ps_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: add the displacement and clamp each coordinate.
    // ------------------------------------------------------------------
    logic signed [DW:0]   sx;
    logic signed [DW:0]   sy;
    logic                 satx;
    logic                 saty;
    logic signed [CW-1:0] cx_next;
    logic signed [CW-1:0] cy_next;
    logic signed [CW-1:0] cx_reg;
    logic signed [CW-1:0] cy_reg;
    logic                 sat_reg;

    always_comb
    begin
        sx = (DW+1)'($signed(rs_reg.px)) + (DW+1)'(dx_reg);
        sy = (DW+1)'($signed(rs_reg.py)) + (DW+1)'(dy_reg);
        satx = 1'b1;
        saty = 1'b1;
        if (sx > (DW+1)'(rdpc_pkg::COORD_MAX))
        begin
            cx_next = rdpc_pkg::COORD_MAX;
        end
        else if (sx < (DW+1)'(rdpc_pkg::COORD_MIN))
        begin
            cx_next = rdpc_pkg::COORD_MIN;
        end
        else
        begin
            cx_next = sx[CW-1:0];
            satx    = 1'b0;
        end
        if (sy > (DW+1)'(rdpc_pkg::COORD_MAX))
        begin
            cy_next = rdpc_pkg::COORD_MAX;
        end
        else if (sy < (DW+1)'(rdpc_pkg::COORD_MIN))
        begin
            cy_next = rdpc_pkg::COORD_MIN;
        end
        else
        begin
            cy_next = sy[CW-1:0];
            saty    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            sat_reg <= satx || saty;
        end
    end

    assign out_valid   = vld_reg[LAT-1];
    assign corrected_x = cx_reg;
    assign corrected_y = cy_reg;
    assign saturated   = sat_reg;

endmodule

// ===== rtl/rdpc_checker.sv =====
module rdpc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_ready,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [rdpc_pkg::COORD_W-1:0] corrected_x,
    input logic signed [rdpc_pkg::COORD_W-1:0] corrected_y,
    input logic                                saturated
);

    // A result that is not taken holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(corrected_x)
            && $stable(corrected_y) && $stable(saturated))
        else $error("result changed while stalled");

    // Input is refused only while a result waits unread.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // The saturation flag implies that a coordinate sits on a rail.
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            corrected_x == rdpc_pkg::COORD_MAX || corrected_x == rdpc_pkg::COORD_MIN
            || corrected_y == rdpc_pkg::COORD_MAX || corrected_y == rdpc_pkg::COORD_MIN)
        else $error("saturation flag without clamped coordinate");

    // Once reset has been seen, no result is presented in the following
    // cycle, and configuration is always open.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid && cfg_ready)
        else $error("result or config stall during reset");

endmodule

bind radar_doppler_point_correction_unit rdpc_checker u_rdpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ready   (cfg_ready),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .corrected_x (corrected_x),
    .corrected_y (corrected_y),
    .saturated   (saturated)
);

// ===== sim/radar_doppler_point_correction_unit_tb.sv =====
`timescale 1ns / 100ps

module radar_doppler_point_correction_unit_tb;

    // Widths and timing constants. The pipeline depth follows the iteration
    // count, and the drain wait at the end of each phase covers it.
    localparam int ANGLE_STEPS    = rdpc_pkg::ANGLE_ITERATIONS_DEF;
    localparam int CW             = rdpc_pkg::COORD_W;
    localparam int RW             = rdpc_pkg::CFG_W;
    localparam int LATENCY        = 2 * ANGLE_STEPS + 6;
    localparam int MAX_WAIT       = 17;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    // Index 3 has no register behind it; writes to it must change nothing.
    localparam logic [rdpc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    // Fixed-point constants of the correction: 1/K^2 in Q30 and the
    // rounding offset that brings the back-rotated shift to Q12.
    localparam longint INV_K2_Q30   = 64'sd395948876;
    localparam longint ROUND_Q38    = 64'sd137438953472;
    localparam longint Q24_SCALE    = 64'sd16777216;
    localparam longint COORD_HI     = 64'sd8388607;
    localparam longint COORD_LO     = -64'sd8388608;

    // One accepted point together with the corrected point it must yield.
    typedef struct {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic                 sat;
    } point_check_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [rdpc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [RW-1:0]                       cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic signed [CW-1:0]                point_x = '0;
    logic signed [CW-1:0]                point_y = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [CW-1:0]                corrected_x;
    logic signed [CW-1:0]                corrected_y;
    logic                                saturated;

    // Shadow copy of the configuration registers, updated on each accepted
    // write transaction.
    logic [RW-1:0]        gain_q16  = rdpc_pkg::DOPPLER_GAIN_RST;
    logic signed [RW-1:0] vel_x_q8  = '0;
    logic signed [RW-1:0] vel_y_q8  = '0;

    point_check_t corrections_due[$];
    int           fail_count = 0;
    int           idle_cycles = 0;
    int           results_seen = 0;
    bit           feed_idle_on = 1'b1;
    bit           sink_idle_on = 1'b1;

    radar_doppler_point_correction_unit #(
        .ANGLE_ITERATIONS(ANGLE_STEPS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .corrected_x(corrected_x),
        .corrected_y(corrected_y),
        .saturated  (saturated)
    );

    always #6 clk = ~clk;

    // Bit-exact prediction of one corrected point. A vectoring CORDIC turns
    // the point onto the x axis and carries the velocity along, so the x part
    // of the turned velocity is the radial speed. The range shift beta*vr is
    // then turned back through the same micro-rotations in reverse order and
    // the squared CORDIC gain is divided out by a Q30 constant.
    function automatic point_check_t correct_point(input logic signed [CW-1:0] px_in,
                                                   input logic signed [CW-1:0] py_in);
        longint       px, py, beta, vx, vy;
        longint       x, y, ux, uy, nx, ny, nux, nuy;
        longint       shift_len, rx, ry, dx, dy, sum_x, sum_y;
        logic [31:0]  turned_cw;
        bit           flip;
        int           i;
        point_check_t res;
        px   = px_in;
        py   = py_in;
        beta = gain_q16;
        vx   = vel_x_q8;
        vy   = vel_y_q8;
        res.px  = px_in;
        res.py  = py_in;
        res.sat = 1'b0;
        if (px == 0 && py == 0)
        begin
            // A point at the origin has bearing zero: the whole shift goes to x.
            dx = (beta * vx + 64'sd2048) >>> 12;
            dy = 0;
        end
        else
        begin
            // Points behind the sensor are turned by pi first so the CORDIC
            // only ever sees the right half plane.
            flip = (px < 0);
            x  = (flip ? -px : px) * Q24_SCALE;
            y  = (flip ? -py : py) * Q24_SCALE;
            ux = (flip ? -vx : vx) * Q24_SCALE;
            uy = (flip ? -vy : vy) * Q24_SCALE;
            turned_cw = '0;
            for (i = 0; i < ANGLE_STEPS; i++)
            begin
                if (y >= 0)
                begin
                    turned_cw[i] = 1'b1;
                    nx  = x + (y >>> i);
                    ny  = y - (x >>> i);
                    nux = ux + (uy >>> i);
                    nuy = uy - (ux >>> i);
                end
                else
                begin
                    nx  = x - (y >>> i);
                    ny  = y + (x >>> i);
                    nux = ux - (uy >>> i);
                    nuy = uy + (ux >>> i);
                end
                x  = nx;
                y  = ny;
                ux = nux;
                uy = nuy;
            end
            shift_len = (beta * ux) >>> 28;
            rx = shift_len;
            ry = 0;
            for (i = ANGLE_STEPS - 1; i >= 0; i--)
            begin
                if (turned_cw[i])
                begin
                    nx = rx - (ry >>> i);
                    ny = ry + (rx >>> i);
                end
                else
                begin
                    nx = rx + (ry >>> i);
                    ny = ry - (rx >>> i);
                end
                rx = nx;
                ry = ny;
            end
            dx = (rx * INV_K2_Q30 + ROUND_Q38) >>> 38;
            dy = (ry * INV_K2_Q30 + ROUND_Q38) >>> 38;
            if (flip)
            begin
                dx = -dx;
                dy = -dy;
            end
        end
        sum_x = px + dx;
        sum_y = py + dy;
        if (sum_x > COORD_HI)
        begin
            sum_x = COORD_HI;
            res.sat = 1'b1;
        end
        else if (sum_x < COORD_LO)
        begin
            sum_x = COORD_LO;
            res.sat = 1'b1;
        end
        if (sum_y > COORD_HI)
        begin
            sum_y = COORD_HI;
            res.sat = 1'b1;
        end
        else if (sum_y < COORD_LO)
        begin
            sum_y = COORD_LO;
            res.sat = 1'b1;
        end
        res.cx = sum_x[CW-1:0];
        res.cy = sum_y[CW-1:0];
        return res;
    endfunction

    function automatic int draw_wait(input bit enabled);
        return enabled ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    // Coordinates are drawn from several pools: full range, small magnitudes
    // of random width, values close to either end of the range (where the
    // shift can saturate) and zero, which puts points on the axes and now and
    // then at the origin.
    function automatic logic signed [CW-1:0] pick_coord();
        logic [CW-1:0] raw;
        int            w;
        raw = CW'($urandom());
        w   = $urandom_range(1, CW - 1);
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return $signed(raw) >>> (CW - w);
            3:       return 24'h7FFFFF - CW'($urandom_range(0, 700000));
            4:       return 24'h800000 + CW'($urandom_range(0, 700000));
            default: return $signed(raw);
        endcase
    endfunction

    function automatic logic [RW-1:0] pick_reg_value();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return rdpc_pkg::DOPPLER_GAIN_RST;
            default: return RW'($urandom());
        endcase
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // One write transaction on the configuration channel. The valid is left
    // high so that writes can follow each other back to back; the caller
    // lowers it after the last one.
    task automatic write_reg(input logic [rdpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [RW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            rdpc_pkg::CFG_DOPPLER_GAIN: gain_q16 = data;
            rdpc_pkg::CFG_VELOCITY_X:   vel_x_q8 = data;
            rdpc_pkg::CFG_VELOCITY_Y:   vel_y_q8 = data;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [RW-1:0] gain,
                                input logic [RW-1:0] vx,
                                input logic [RW-1:0] vy);
        write_reg(rdpc_pkg::CFG_DOPPLER_GAIN, gain);
        write_reg(rdpc_pkg::CFG_VELOCITY_X, vx);
        write_reg(rdpc_pkg::CFG_VELOCITY_Y, vy);
        cfg_valid <= 1'b0;
    endtask

    // Sends one point. After an optional gap the valid rises and stays high
    // with a steady payload until the transaction is taken; the expected
    // correction is queued at that edge with the configuration in force.
    task automatic send_point(input logic signed [CW-1:0] x,
                              input logic signed [CW-1:0] y);
        int gap;
        gap = draw_wait(feed_idle_on);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x  <= x;
        point_y  <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        corrections_due.insert(corrections_due.size(), correct_point(x, y));
    endtask

    // Brings the input side to rest and waits until every queued correction
    // has come back, then waits longer than the pipeline depth so that a stray extra
    // result would still be seen before the registers change.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (corrections_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Reset values: beta at its default and zero velocity leave every point
    // where it is, the origin included.
    task automatic test_reset_defaults();
        wait_drained();
        send_point('0, '0);
        send_point(24'sh7FFFFF, 24'sh7FFFFF);
        send_point(-24'sd1, 24'sd5);
    endtask

    // Largest gain and velocity: the axes, the corners of the coordinate
    // range, the negative half plane and the origin, with saturation at the
    // edges.
    task automatic test_extreme_points();
        wait_drained();
        program_regs(16'hFFFF, 16'h7FFF, 16'h8000);
        send_point('0, '0);
        send_point(24'sh7FFFFF, '0);
        send_point(24'sh800000, '0);
        send_point('0, 24'sh7FFFFF);
        send_point('0, 24'sh800000);
        send_point(24'sh7FFFFF, 24'sh7FFFFF);
        send_point(24'sh800000, 24'sh800000);
        send_point(24'sh800000, 24'sh7FFFFF);
        send_point(24'sh7FFFFF, 24'sh800000);
        send_point(-24'sd1, '0);
        send_point('0, 24'sd1);
        send_point(24'sd1, -24'sd1);
    endtask

    // Opposite signs of the velocity, so the shift runs toward the sensor.
    task automatic test_reversed_velocity();
        wait_drained();
        program_regs(16'hFFFF, 16'h8000, 16'h7FFF);
        send_point('0, '0);
        send_point(24'sh800000, 24'sd3);
        send_point(24'sh7FFF00, 24'sh7FFF00);
        send_point(-24'sd100000, 24'sd3);
    endtask

    // Zero gain removes any shift; a write to the unmapped index must leave
    // all three registers untouched.
    task automatic test_zero_gain_and_unmapped_index();
        wait_drained();
        program_regs(16'h0000, 16'h7FFF, 16'h7FFF);
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_point(24'sd123456, -24'sd654321);
        send_point('0, '0);
    endtask

    // Random points in six settings: two fixed corners of the register space,
    // one with a realistic small velocity, the rest drawn at random with a
    // bias toward the extremes. The sender switches between idling and
    // streaming every few dozen transactions.
    task automatic test_random_points();
        int phase;
        int n;
        for (phase = 0; phase < 6; phase++)
        begin
            wait_drained();
            case (phase)
                0: program_regs(16'hFFFF, 16'h8000, 16'h8000);
                1: program_regs(16'h0001, 16'h7FFF, 16'h0000);
                2: program_regs(rdpc_pkg::DOPPLER_GAIN_RST,
                                RW'($urandom_range(0, 5120) - 2560),
                                RW'($urandom_range(0, 2560) - 1280));
                default: program_regs(pick_reg_value(), pick_reg_value(), pick_reg_value());
            endcase
            for (n = 0; n < 171; n++)
            begin
                if (n % 40 == 0)
                    feed_idle_on = ($urandom_range(0, 3) != 0);
                send_point(pick_coord(), pick_coord());
            end
        end
        feed_idle_on = 1'b1;
    endtask

    // Result side: before each result the receiver holds ready low for a
    // drawn number of cycles, then keeps it high until a transaction is taken
    // and compares it with the oldest queued correction.
    initial
    begin : result_check
        int           stall;
        point_check_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(sink_idle_on);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            results_seen++;
            if (results_seen % 32 == 0)
                sink_idle_on = ($urandom_range(0, 2) != 0);
            if (corrections_due.size() == 0)
            begin
                note_failure($sformatf("unrequested result x=%0d y=%0d sat=%0b",
                                       corrected_x, corrected_y, saturated));
            end
            else
            begin
                want = corrections_due.pop_front();
                if (corrected_x !== want.cx || corrected_y !== want.cy ||
                    saturated !== want.sat)
                    note_failure($sformatf(
                        "point (%0d,%0d): expected x=%0d y=%0d sat=%0b, got x=%0d y=%0d sat=%0b",
                        want.px, want.py, want.cx, want.cy, want.sat,
                        corrected_x, corrected_y, saturated));
            end
        end
    end

    // Watchdog: a long stretch without any accepted transaction on any
    // channel means the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("radar_doppler_point_correction_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_extreme_points();
        test_reversed_velocity();
        test_zero_gain_and_unmapped_index();
        test_random_points();
        wait_drained();
        if (fail_count == 0 && corrections_due.size() == 0)
            $display("radar_doppler_point_correction_unit: match");
        else
            $display("radar_doppler_point_correction_unit: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rdpc_pkg.sv
rtl/radar_doppler_point_correction_unit.sv
rtl/rdpc_checker.sv
sim/radar_doppler_point_correction_unit_tb.sv
